// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds the request/response payload structs, command codes and cell constants.
// No dependencies.
`default_nettype none

package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Payload field widths
    localparam int CHAR_W       = 8;
    localparam int INDEX_W      = 11;
    localparam int CELL_W       = 16;
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;

    // Command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register select (paddr bit 2): text color is the only register
    localparam logic REG_TEXT_COLOR = 1'b0;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {RESET_COLOR, BLANK_CODE};

    typedef struct packed {
        logic                    cmd;
        logic [CHAR_W-1:0]       char_code;
        logic [INDEX_W-1:0]      read_index;
    } tcw_req_t;

    typedef struct packed {
        logic [CELL_W-1:0]       cell_data;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_col;
        logic                    scrolled;
    } tcw_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Text console writer top level: screen store, cursor, scroll control, APB register.
// Depends on tcw_pkg (types, constants) and tcw_ram (screen cell store).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | tcw_req_t: cmd, char, index
//  rsp     | out       | rsp_valid/rsp_ready  | tcw_rsp_t: cell, cursor, scroll
//  apb     | in/out    | psel/penable/pready  | text_color at byte address 0
//
// A put is done in ST_IDLE; a read also passes ST_READ for the registered RAM read.
// A put that scrolls then runs ST_CLEAR: rows live in the RAM as a ring
// with a top-row offset, and the reused row is cleared one cell per cycle.
// After reset a clearing pass writes blanks to all ROWS*COLUMNS cells
// with req_ready low; register writes are taken meanwhile.
// A result waits in a one-entry slot ahead of the output register, so the next
// item is taken while the previous transfer is stalled on rsp_ready.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output      logic              req_ready,
    input  wire tcw_pkg::tcw_req_t req,
    output      logic              rsp_valid,
    input  wire logic              rsp_ready,
    output      tcw_pkg::tcw_rsp_t rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);

    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int SUM_W      = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] init_addr_reg, init_addr_next;
    logic [COL_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] clr_base_reg, clr_base_next;
    logic [CHAR_W-1:0] clr_attr_reg, clr_attr_next;
    logic [ADDR_W-1:0] top_base_reg, top_base_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [CHAR_W-1:0] text_color_reg;
    logic              rd_oob_reg, rd_oob_next;
    logic              res_pending_reg, res_pending_next;
    tcw_rsp_t          res_reg, res_next;
    logic              rsp_valid_reg;
    tcw_rsp_t          rsp_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic              rsp_load;
    logic              req_fire;
    logic              is_nl;
    logic [COL_W:0]    col_inc;
    logic              wrap_row;
    logic              last_row;
    logic              put_scroll;
    logic [ADDR_W-1:0] put_addr;
    logic [CELL_W-1:0] put_cell;
    logic [ADDR_W:0]   row_base_sum;
    logic [ADDR_W-1:0] row_base_adv;
    logic [ADDR_W:0]   top_base_sum;
    logic [ADDR_W-1:0] top_base_adv;
    logic [SUM_W-1:0]  rd_sum;
    logic              rd_in_range;
    logic [ADDR_W-1:0] rd_phys;
    logic              cfg_write;

    // Screen cell store
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else if (cfg_write && (paddr[2] == REG_TEXT_COLOR))
        begin
            text_color_reg <= pwdata[CHAR_W-1:0];
        end
    end

    // Advance ring addresses by one row, wrapping at the end of the store
    always_comb
    begin
        row_base_sum = {1'b0, row_base_reg} + (ADDR_W+1)'(COLUMNS);
        row_base_adv = (row_base_sum >= (ADDR_W+1)'(CELL_COUNT))
                     ? ADDR_W'(row_base_sum - (ADDR_W+1)'(CELL_COUNT))
                     : row_base_sum[ADDR_W-1:0];
        top_base_sum = {1'b0, top_base_reg} + (ADDR_W+1)'(COLUMNS);
        top_base_adv = (top_base_sum >= (ADDR_W+1)'(CELL_COUNT))
                     ? ADDR_W'(top_base_sum - (ADDR_W+1)'(CELL_COUNT))
                     : top_base_sum[ADDR_W-1:0];
    end

    // Map a logical read index onto the ring
    always_comb
    begin
        rd_in_range = SUM_W'(req.read_index) < SUM_W'(CELL_COUNT);
        rd_sum      = SUM_W'(req.read_index) + SUM_W'(top_base_reg);
        rd_phys     = (rd_sum >= SUM_W'(CELL_COUNT))
                    ? ADDR_W'(rd_sum - SUM_W'(CELL_COUNT))
                    : ADDR_W'(rd_sum);
    end

    // Cursor step for a put
    always_comb
    begin
        is_nl      = (req.char_code == NEWLINE_CODE);
        col_inc    = {1'b0, cur_col_reg} + (COL_W+1)'(1);
        wrap_row   = is_nl || (col_inc == (COL_W+1)'(COLUMNS));
        last_row   = (cur_row_reg == ROW_W'(ROWS - 1));
        put_scroll = wrap_row && last_row;
        put_addr   = row_base_reg + ADDR_W'(cur_col_reg);
        put_cell   = {text_color_reg, req.char_code};
    end

    // Handshake
    assign rsp_load  = res_pending_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == ST_IDLE) && (!res_pending_reg || rsp_load);
    assign req_fire  = req_valid && req_ready;

    // Sequencer: post-reset fill, character puts, cell reads and row clears of the store and cursor
    always_comb
    begin
        state_next       = state_reg;
        init_addr_next   = init_addr_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_base_next    = clr_base_reg;
        clr_attr_next    = clr_attr_reg;
        top_base_next    = top_base_reg;
        row_base_next    = row_base_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        rd_oob_next      = rd_oob_reg;
        res_pending_next = res_pending_reg && !rsp_load;
        res_next         = res_reg;
        mem_we           = 1'b0;
        mem_waddr        = put_addr;
        mem_wdata        = put_cell;
        mem_re           = 1'b0;
        mem_raddr        = rd_phys;

        unique case (state_reg)
            ST_INIT:
            begin
                // Fill the store with blanks after reset
                mem_we    = 1'b1;
                mem_waddr = init_addr_reg;
                mem_wdata = BLANK_CELL;
                if (init_addr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    init_addr_next = init_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.cmd == CMD_READ)
                    begin
                        mem_re      = 1'b1;
                        rd_oob_next = !rd_in_range;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        // Write the character (not for a newline) and move the cursor
                        mem_we = !is_nl;
                        if (!wrap_row)
                        begin
                            cur_col_next = col_inc[COL_W-1:0];
                        end
                        else if (last_row)
                        begin
                            cur_col_next  = '0;
                            row_base_next = top_base_reg;
                            top_base_next = top_base_adv;
                            clr_cnt_next  = '0;
                            clr_base_next = top_base_reg;
                            clr_attr_next = text_color_reg;
                            state_next    = ST_CLEAR;
                        end
                        else
                        begin
                            cur_col_next  = '0;
                            cur_row_next  = cur_row_reg + ROW_W'(1);
                            row_base_next = row_base_adv;
                        end
                        res_pending_next     = 1'b1;
                        res_next.cell_data   = is_nl ? '0 : put_cell;
                        res_next.cursor_row  = put_scroll ? CURSOR_ROW_W'(ROWS - 1)
                                             : (wrap_row ? CURSOR_ROW_W'(cur_row_reg + ROW_W'(1))
                                                         : CURSOR_ROW_W'(cur_row_reg));
                        res_next.cursor_col  = wrap_row ? '0
                                             : CURSOR_COL_W'(col_inc[COL_W-1:0]);
                        res_next.scrolled    = put_scroll;
                    end
                end
            end
            ST_READ:
            begin
                // Capture the registered RAM data
                res_pending_next    = 1'b1;
                res_next.cell_data  = rd_oob_reg ? '0 : mem_rdata;
                res_next.cursor_row = CURSOR_ROW_W'(cur_row_reg);
                res_next.cursor_col = CURSOR_COL_W'(cur_col_reg);
                res_next.scrolled   = 1'b0;
                state_next          = ST_IDLE;
            end
            ST_CLEAR:
            begin
                // Blank the reused bottom row one cell per cycle
                mem_we    = 1'b1;
                mem_waddr = clr_base_reg + ADDR_W'(clr_cnt_reg);
                mem_wdata = {clr_attr_reg, BLANK_CODE};
                if (clr_cnt_reg == COL_W'(COLUMNS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + COL_W'(1);
                end
            end
        endcase
    end

    // Control and cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            init_addr_reg   <= '0;
            clr_cnt_reg     <= '0;
            top_base_reg    <= '0;
            row_base_reg    <= '0;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            res_pending_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_addr_reg   <= init_addr_next;
            clr_cnt_reg     <= clr_cnt_next;
            top_base_reg    <= top_base_next;
            row_base_reg    <= row_base_next;
            cur_row_reg     <= cur_row_next;
            cur_col_reg     <= cur_col_next;
            res_pending_reg <= res_pending_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        clr_base_reg <= clr_base_next;
        clr_attr_reg <= clr_attr_next;
        rd_oob_reg   <= rd_oob_next;
        res_reg      <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cur_col_reg} < (COL_W+1)'(COLUMNS)) && (cur_row_reg <= ROW_W'(ROWS - 1)))
        else $error("cursor out of screen range");

    a_scroll_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.cmd == CMD_PUT) && put_scroll) |=> (state_reg == ST_CLEAR))
        else $error("scroll did not start row clear");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !mem_we)
        else $error("store written while read data pending");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.scrolled) |->
            ((rsp.cursor_col == '0) && (rsp.cursor_row == CURSOR_ROW_W'(ROWS - 1))))
        else $error("scrolled result with cursor off the last row start");

endmodule

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the screen cell store. No package dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
